### src/rist_pkg.sv
// Shared types, codes and constants for the record id slot table.
`default_nettype none
package rist_pkg;

  localparam int PAGE_COUNT_DEF = 512;
  localparam int SLOTS_PER_PAGE_DEF = 8;
  localparam logic [31:0] ID_MAX = 32'hFFFF_FFFF;

  // Action codes
  localparam logic [2:0] ACT_LOAD    = 3'd0;
  localparam logic [2:0] ACT_DONE    = 3'd1;
  localparam logic [2:0] ACT_STORE   = 3'd2;
  localparam logic [2:0] ACT_DELETE  = 3'd3;
  localparam logic [2:0] ACT_PENDING = 3'd4;
  localparam logic [2:0] ACT_NEWID   = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ERR     = 2'd1;
  localparam logic [1:0] ST_NONE    = 2'd2;
  localparam logic [1:0] ST_NOTFND  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_THRESH = 2'd0;
  localparam logic [1:0] CFG_FPAGE  = 2'd1;
  localparam logic [1:0] CFG_FID    = 2'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic [8:0]  page;
    logic [2:0]  slot;
    logic [31:0] record_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  found_page;
    logic [2:0]  found_slot;
    logic [31:0] result_id;
  } out_item_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic [2:0]  action;
    logic        direct;     // answer with stat/page/slot directly, no table walk
    logic        wr;         // direct write of the load slot
    logic [1:0]  stat;
    logic [8:0]  page;
    logic [2:0]  slot;
    logic [31:0] record_id;
  } cmd_t;

endpackage
`default_nettype wire

### src/record_id_slot_table_top.sv
// Top level of the record id slot table: config registers, front end and back end.
//  channel | ports                         | handshake
//  input   | start, busy, in_item          | accepted when start && !busy
//  result  | out_valid, out_item           | one-cycle strobe, no stall
//  config  | cfg_valid, cfg_ready, cfg_*   | written when valid && ready
// A table walk reads the slots from first_page up to the last slot through the
// single read port of the table memory, stopping early on a hit; direct actions
// skip the walk. After reset a clearing pass writes zero to every table slot
// before the first item is carried out; items queue meanwhile. The receiver
// cannot stall results.
`default_nettype none
module record_id_slot_table_top #(
  parameter int PAGE_COUNT = rist_pkg::PAGE_COUNT_DEF,
  parameter int SLOTS_PER_PAGE = rist_pkg::SLOTS_PER_PAGE_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire rist_pkg::in_item_t  in_item,
  output logic                     out_valid,
  output rist_pkg::out_item_t      out_item,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_data
);

  logic [31:0] thresh_r;
  logic [8:0]  fpage_r;
  logic [31:0] fid_r;
  logic        cmd_valid, cmd_take;
  rist_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= '0;
      fpage_r <= 9'd1;
      fid_r <= 32'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rist_pkg::CFG_THRESH: thresh_r <= cfg_data;
        rist_pkg::CFG_FPAGE:  fpage_r <= cfg_data[8:0];
        rist_pkg::CFG_FID:    fid_r <= cfg_data;
        default: ;
      endcase
    end
  end

  rist_front #(.PAGE_COUNT(PAGE_COUNT), .SLOTS_PER_PAGE(SLOTS_PER_PAGE)) u_front (
    .clk, .rst_n, .start, .busy, .in_item,
    .first_page(fpage_r), .cmd_valid, .cmd, .cmd_take
  );

  rist_back #(.PAGE_COUNT(PAGE_COUNT), .SLOTS_PER_PAGE(SLOTS_PER_PAGE)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_take,
    .sent_threshold(thresh_r), .first_page(fpage_r), .first_id(fid_r),
    .out_valid, .out_item
  );

endmodule
`default_nettype wire

### src/rist_front.sv
// Front end: accepts commands, classifies them and queues them for the back end.
`default_nettype none
module rist_front #(
  parameter int PAGE_COUNT = rist_pkg::PAGE_COUNT_DEF,
  parameter int SLOTS_PER_PAGE = rist_pkg::SLOTS_PER_PAGE_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire rist_pkg::in_item_t in_item,
  input  wire logic [8:0]        first_page,
  output logic                   cmd_valid,
  output rist_pkg::cmd_t         cmd,
  input  wire logic              cmd_take
);

  rist_pkg::cmd_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rp_r, wp_r;
  logic       ready_r;
  rist_pkg::cmd_t c;
  logic       acc;

  assign busy = (cnt_r == 2'd2);
  assign acc  = start && !busy;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd = q_r[rp_r];

  // classify the incoming transaction
  always_comb begin
    c = '0;
    c.action = in_item.action;
    c.page = in_item.page;
    c.slot = in_item.slot;
    c.record_id = in_item.record_id;
    c.direct = 1'b1;
    c.stat = rist_pkg::ST_ERR;
    c.page = '0;
    c.slot = '0;
    if (in_item.action == rist_pkg::ACT_LOAD) begin
      if (32'(in_item.page) < PAGE_COUNT && 32'(in_item.slot) < SLOTS_PER_PAGE) begin
        c.stat = rist_pkg::ST_OK;
        c.wr = 1'b1;
        c.page = in_item.page;
        c.slot = in_item.slot;
      end
    end else if (in_item.action == rist_pkg::ACT_DONE) begin
      c.stat = rist_pkg::ST_OK;
    end else if (in_item.action > rist_pkg::ACT_NEWID || !ready_r) begin
      c.stat = rist_pkg::ST_ERR;
    end else if (in_item.action == rist_pkg::ACT_NEWID) begin
      c.direct = 1'b0;
    end else if (first_page == 9'd0) begin
      c.stat = rist_pkg::ST_ERR;
    end else begin
      c.direct = 1'b0;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, acc} - {1'b0, cmd_take};
  end

  // two-entry queue, table ready flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rp_r <= 1'b0;
      wp_r <= 1'b0;
      ready_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (acc) begin
        wp_r <= ~wp_r;
        if (in_item.action == rist_pkg::ACT_DONE) ready_r <= 1'b1;
      end
      if (cmd_take) rp_r <= ~rp_r;
    end
    if (acc) q_r[wp_r] <= c;
  end

endmodule
`default_nettype wire

### src/rist_back.sv
// Back end: holds the id table and walks it slot by slot for each command that is not direct.
`default_nettype none
module rist_back #(
  parameter int PAGE_COUNT = rist_pkg::PAGE_COUNT_DEF,
  parameter int SLOTS_PER_PAGE = rist_pkg::SLOTS_PER_PAGE_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cmd_valid,
  input  wire rist_pkg::cmd_t     cmd,
  output logic                    cmd_take,
  input  wire logic [31:0]        sent_threshold,
  input  wire logic [8:0]         first_page,
  input  wire logic [31:0]        first_id,
  output logic                    out_valid,
  output rist_pkg::out_item_t     out_item
);

  localparam int SW = (SLOTS_PER_PAGE > 1) ? $clog2(SLOTS_PER_PAGE) : 1;
  localparam int PW = $clog2(PAGE_COUNT);
  localparam int DEPTH = PAGE_COUNT * SLOTS_PER_PAGE;
  localparam int AW = $clog2(DEPTH);
  localparam logic [PW-1:0] PLAST = PW'(PAGE_COUNT - 1);
  localparam logic [SW-1:0] SLAST = SW'(SLOTS_PER_PAGE - 1);

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_RD   = 6'b000100,
    S_CHK  = 6'b001000,
    S_WR   = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;
  logic [AW-1:0] clr_r;
  logic [PW-1:0] pg_r;
  logic [SW-1:0] sl_r;
  logic          rdv_r;
  logic [PW-1:0] rpg_r;
  logic [SW-1:0] rsl_r;
  logic          last_r;
  logic          fin_r;
  logic          have_r;
  logic [31:0]   best_r;
  logic [PW-1:0] bp_r;
  logic [SW-1:0] bs_r;
  logic [1:0]    stat_r;
  rist_pkg::cmd_t cur_r;
  logic          hit;
  logic          walk_last;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic          we;
  logic [32:0]   r1, r2;
  rist_pkg::out_item_t res_nxt;

  function automatic logic [AW-1:0] addr_of(input logic [PW-1:0] p, input logic [SW-1:0] s);
    logic [AW:0] a;
    a = (AW+1)'(p) * (AW+1)'(SLOTS_PER_PAGE) + (AW+1)'(s);
    return a[AW-1:0];
  endfunction

  assign cmd_take = (state_r == S_IDLE) && cmd_valid;
  assign raddr = addr_of(pg_r, sl_r);
  assign walk_last = (pg_r == PLAST) && (sl_r == SLAST);

  // per-slot test of the walk
  always_comb begin
    hit = 1'b0;
    unique case (cur_r.action)
      rist_pkg::ACT_STORE:   hit = (rdata_r == 32'd0);
      rist_pkg::ACT_DELETE:  hit = (cur_r.record_id != 32'd0) && (rdata_r == cur_r.record_id);
      default:               hit = 1'b0;
    endcase
  end

  // table write port
  always_comb begin
    we = 1'b0;
    waddr = clr_r;
    wdata = '0;
    if (state_r == S_CLR) begin
      we = 1'b1;
    end else if (state_r == S_WR) begin
      we = 1'b1;
      if (cur_r.action == rist_pkg::ACT_LOAD) begin
        waddr = addr_of(PW'(cur_r.page), SW'(cur_r.slot));
        wdata = cur_r.record_id;
      end else begin
        waddr = addr_of(bp_r, bs_r);
        wdata = (cur_r.action == rist_pkg::ACT_STORE) ? cur_r.record_id : 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign r1 = {1'b0, best_r} + 33'd1;
  assign r2 = {1'b0, sent_threshold} + 33'd1;

  // result word
  always_comb begin
    res_nxt = '0;
    res_nxt.status = stat_r;
    if (cur_r.direct) begin
      res_nxt.found_page = cur_r.page;
      res_nxt.found_slot = cur_r.slot;
    end else if (stat_r == rist_pkg::ST_OK) begin
      unique case (cur_r.action)
        rist_pkg::ACT_NEWID: begin
          if (r1 > r2) res_nxt.result_id = r1[32] ? rist_pkg::ID_MAX : r1[31:0];
          else res_nxt.result_id = r2[32] ? rist_pkg::ID_MAX : r2[31:0];
        end
        rist_pkg::ACT_PENDING: begin
          res_nxt.found_page = 9'(bp_r);
          res_nxt.found_slot = 3'(bs_r);
          res_nxt.result_id = best_r;
        end
        default: begin
          res_nxt.found_page = 9'(bp_r);
          res_nxt.found_slot = 3'(bs_r);
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:  if (clr_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE: if (cmd_valid) begin
        if (cmd.direct) state_nxt = cmd.wr ? S_WR : S_OUT;
        else if (32'(first_page) >= PAGE_COUNT) state_nxt = S_OUT;
        else state_nxt = S_RD;
      end
      S_RD:   if (fin_r) state_nxt = S_CHK;
      S_CHK:  state_nxt = (stat_r == rist_pkg::ST_OK &&
                          (cur_r.action == rist_pkg::ACT_STORE ||
                           cur_r.action == rist_pkg::ACT_DELETE)) ? S_WR : S_OUT;
      S_WR:   state_nxt = S_OUT;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      rdv_r <= 1'b0;
      fin_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid <= (state_r == S_OUT);
      if (state_r == S_CLR) clr_r <= clr_r + AW'(1);
      // a read is in flight unless the walk just ended on a hit or on the last slot
      rdv_r <= (state_r == S_RD) && !fin_r && !(rdv_r && (hit || last_r));
      if (state_r == S_IDLE) fin_r <= 1'b0;
      if (state_r == S_RD && !fin_r) begin
        // issue reads; stop scanning once a hit or the last slot has been checked
        last_r <= walk_last;
        rpg_r <= pg_r;
        rsl_r <= sl_r;
        if (sl_r == SLAST) begin
          sl_r <= '0;
          pg_r <= pg_r + PW'(1);
        end else begin
          sl_r <= sl_r + SW'(1);
        end
      end
      if (rdv_r && !fin_r) begin
        if (hit) begin
          fin_r <= 1'b1;
          have_r <= 1'b1;
          stat_r <= rist_pkg::ST_OK;
          bp_r <= rpg_r;
          bs_r <= rsl_r;
        end else begin
          if (last_r) begin
            fin_r <= 1'b1;
          end
          unique case (cur_r.action)
            rist_pkg::ACT_STORE: if (!have_r || rdata_r < best_r) begin
              have_r <= 1'b1; best_r <= rdata_r; bp_r <= rpg_r; bs_r <= rsl_r;
            end
            rist_pkg::ACT_PENDING:
              if (rdata_r > sent_threshold && (!have_r || rdata_r < best_r)) begin
                have_r <= 1'b1; best_r <= rdata_r; bp_r <= rpg_r; bs_r <= rsl_r;
              end
            rist_pkg::ACT_NEWID: if (rdata_r > best_r) best_r <= rdata_r;
            default: ;
          endcase
          if (last_r) begin
            if (cur_r.action == rist_pkg::ACT_DELETE) stat_r <= rist_pkg::ST_NOTFND;
            else if (cur_r.action == rist_pkg::ACT_PENDING) begin
              if (!(have_r || (rdata_r > sent_threshold))) stat_r <= rist_pkg::ST_NONE;
              else stat_r <= rist_pkg::ST_OK;
            end else stat_r <= rist_pkg::ST_OK;
          end
        end
      end
    end
    // command load; an empty search range answers without a walk
    if (state_r == S_IDLE && cmd_valid) begin
      cur_r <= cmd;
      pg_r <= PW'(first_page);
      sl_r <= '0;
      have_r <= 1'b0;
      best_r <= (cmd.action == rist_pkg::ACT_NEWID) ? first_id : 32'd0;
      bp_r <= '0;
      bs_r <= '0;
      if (cmd.direct) stat_r <= cmd.stat;
      else if (32'(first_page) < PAGE_COUNT) stat_r <= rist_pkg::ST_ERR;
      else if (cmd.action == rist_pkg::ACT_DELETE) stat_r <= rist_pkg::ST_NOTFND;
      else if (cmd.action == rist_pkg::ACT_PENDING) stat_r <= rist_pkg::ST_NONE;
      else if (cmd.action == rist_pkg::ACT_NEWID) stat_r <= rist_pkg::ST_OK;
      else stat_r <= rist_pkg::ST_ERR;
    end
    // result register
    if (state_r == S_OUT) out_item <= res_nxt;
  end

endmodule
`default_nettype wire

### test/record_id_slot_table_top_tb.sv
// Self-checking testbench for the record id slot table: directed table, then random actions.
`timescale 1ns / 100ps
module record_id_slot_table_top_tb;

  localparam int NPAGE = rist_pkg::PAGE_COUNT_DEF;
  localparam int NSLOT = rist_pkg::SLOTS_PER_PAGE_DEF;
  localparam int NTAB = NPAGE * NSLOT;
  localparam int RAND_ITEMS = 116;
  localparam longint CYCLE_LIMIT = 3_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  rist_pkg::in_item_t in_item = '0;
  logic out_valid;
  rist_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  record_id_slot_table_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the table and registers
  logic [31:0] shadow_ids [NTAB];
  logic shadow_ready;
  logic [31:0] shadow_thresh;
  logic [8:0] shadow_fpage;
  logic [31:0] shadow_fid;

  rist_pkg::out_item_t answer_q[$];
  int errors = 0;
  longint cycles = 0;

  // Directed rows; check_exp set where the answer is fixed
  typedef struct {
    rist_pkg::in_item_t item;
    bit check_exp;
    rist_pkg::out_item_t exp;
  } row_t;

  function automatic rist_pkg::out_item_t mk_out(logic [1:0] st, logic [8:0] pg,
                                                 logic [2:0] sl, logic [31:0] id);
    rist_pkg::out_item_t o;
    o.status = st; o.found_page = pg; o.found_slot = sl; o.result_id = id;
    return o;
  endfunction

  function automatic rist_pkg::in_item_t mk_in(logic [2:0] a, logic [8:0] pg, logic [2:0] sl,
                                               logic [31:0] id);
    rist_pkg::in_item_t i;
    i.action = a; i.page = pg; i.slot = sl; i.record_id = id;
    return i;
  endfunction

  // Predict the table answer and update the shadow state
  function automatic rist_pkg::out_item_t table_answer(rist_pkg::in_item_t it);
    logic [31:0] best, v, m;
    logic [32:0] r;
    bit have;
    int bi, idx;
    best = '0; have = 0; bi = 0;
    case (it.action)
      rist_pkg::ACT_LOAD: begin
        shadow_ids[it.page * NSLOT + it.slot] = it.record_id;
        return mk_out(rist_pkg::ST_OK, it.page, it.slot, '0);
      end
      rist_pkg::ACT_DONE: begin
        shadow_ready = 1'b1;
        return mk_out(rist_pkg::ST_OK, '0, '0, '0);
      end
      default: ;
    endcase
    if (it.action > rist_pkg::ACT_NEWID || !shadow_ready)
      return mk_out(rist_pkg::ST_ERR, '0, '0, '0);
    if (it.action == rist_pkg::ACT_NEWID) begin
      m = shadow_fid;
      for (idx = shadow_fpage * NSLOT; idx < NTAB; idx++)
        if (shadow_ids[idx] > m) m = shadow_ids[idx];
      r = {1'b0, m} + 33'd1;
      if (r <= {1'b0, shadow_thresh}) r = {1'b0, shadow_thresh} + 33'd1;
      if (r > {1'b0, rist_pkg::ID_MAX}) r = {1'b0, rist_pkg::ID_MAX};
      return mk_out(rist_pkg::ST_OK, '0, '0, r[31:0]);
    end
    if (shadow_fpage == 0) return mk_out(rist_pkg::ST_ERR, '0, '0, '0);
    if (it.action == rist_pkg::ACT_STORE) begin
      for (idx = shadow_fpage * NSLOT; idx < NTAB; idx++) begin
        v = shadow_ids[idx];
        if (v == 0) begin
          shadow_ids[idx] = it.record_id;
          return mk_out(rist_pkg::ST_OK, 9'(idx / NSLOT), 3'(idx % NSLOT), '0);
        end
        if (!have || v < best) begin
          have = 1; best = v; bi = idx;
        end
      end
      if (!have) return mk_out(rist_pkg::ST_ERR, '0, '0, '0);
      shadow_ids[bi] = it.record_id;
      return mk_out(rist_pkg::ST_OK, 9'(bi / NSLOT), 3'(bi % NSLOT), '0);
    end
    if (it.action == rist_pkg::ACT_DELETE) begin
      if (it.record_id != 0)
        for (idx = shadow_fpage * NSLOT; idx < NTAB; idx++)
          if (shadow_ids[idx] == it.record_id) begin
            shadow_ids[idx] = '0;
            return mk_out(rist_pkg::ST_OK, 9'(idx / NSLOT), 3'(idx % NSLOT), '0);
          end
      return mk_out(rist_pkg::ST_NOTFND, '0, '0, '0);
    end
    // next pending
    for (idx = shadow_fpage * NSLOT; idx < NTAB; idx++) begin
      v = shadow_ids[idx];
      if (v > shadow_thresh && (!have || v < best)) begin
        have = 1; best = v; bi = idx;
      end
    end
    if (!have) return mk_out(rist_pkg::ST_NONE, '0, '0, '0);
    return mk_out(rist_pkg::ST_OK, 9'(bi / NSLOT), 3'(bi % NSLOT), best);
  endfunction

  // Send one transaction, predict and queue its answer; start stays up for a burst
  task automatic send_item(rist_pkg::in_item_t it, bit check_exp, rist_pkg::out_item_t exp);
    rist_pkg::out_item_t pred;
    pred = table_answer(it);
    if (check_exp && pred != exp) begin
      $display("%0t: directed row disagrees: table %h, typed %h", $time, pred, exp);
      errors++;
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    answer_q.push_back(pred);
  endtask

  // Random gap between bursts
  task automatic sender_gap();
    int n;
    if ($urandom_range(3) == 0) begin
      n = $urandom_range(6, 1);
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // One register write; the caller drops cfg_valid after the last one
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      rist_pkg::CFG_THRESH: shadow_thresh = val;
      rist_pkg::CFG_FPAGE:  shadow_fpage = val[8:0];
      rist_pkg::CFG_FID:    shadow_fid = val;
      default: ;
    endcase
  endtask

  // Result checker
  always @(posedge clk) begin
    rist_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_item);
        errors++;
      end else begin
        want = answer_q.pop_front();
        if (out_item.status !== want.status)
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_item.status);
        if (out_item.found_page !== want.found_page)
          $display("%0t: found_page expected %0d actual %0d", $time, want.found_page,
                   out_item.found_page);
        if (out_item.found_slot !== want.found_slot)
          $display("%0t: found_slot expected %0d actual %0d", $time, want.found_slot,
                   out_item.found_slot);
        if (out_item.result_id !== want.result_id)
          $display("%0t: result_id expected %h actual %h", $time, want.result_id,
                   out_item.result_id);
        if (out_item !== want) errors++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Random id: half of the time from a small pool so deletes and stores hit
  function automatic logic [31:0] rand_id();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'd0;
      2: return rist_pkg::ID_MAX - $urandom_range(3);
      default: return $urandom_range(40);
    endcase
  endfunction

  // Random page: mostly near the low search range
  function automatic logic [8:0] rand_page();
    if ($urandom_range(4) == 0) return 9'($urandom_range(NPAGE - 1));
    return 9'($urandom_range(4));
  endfunction

  row_t rows[$];
  rist_pkg::in_item_t it;
  int i, ph;
  logic [31:0] thr_set [4] = '{32'd0, 32'd20, rist_pkg::ID_MAX, 32'd5};
  logic [31:0] fid_set [4] = '{32'd1, 32'd0, rist_pkg::ID_MAX, 32'd30};
  logic [8:0] fpg_set [4] = '{9'd1, 9'd0, 9'd511, 9'd2};

  initial begin
    for (i = 0; i < NTAB; i++) shadow_ids[i] = '0;
    shadow_ready = 1'b0; shadow_thresh = '0; shadow_fpage = 9'd1; shadow_fid = 32'd1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: not ready errors, extremes of loads, unknown actions, ready
    rows.push_back('{mk_in(rist_pkg::ACT_STORE, 0, 0, 5), 1,
                     mk_out(rist_pkg::ST_ERR, 0, 0, 0)});
    rows.push_back('{mk_in(rist_pkg::ACT_DELETE, 0, 0, 5), 1,
                     mk_out(rist_pkg::ST_ERR, 0, 0, 0)});
    rows.push_back('{mk_in(rist_pkg::ACT_PENDING, 0, 0, 0), 1,
                     mk_out(rist_pkg::ST_ERR, 0, 0, 0)});
    rows.push_back('{mk_in(rist_pkg::ACT_NEWID, 0, 0, 0), 1,
                     mk_out(rist_pkg::ST_ERR, 0, 0, 0)});
    rows.push_back('{mk_in(3'd6, 9'h1FF, 7, rist_pkg::ID_MAX), 1,
                     mk_out(rist_pkg::ST_ERR, 0, 0, 0)});
    rows.push_back('{mk_in(rist_pkg::ACT_LOAD, 9'd511, 7, rist_pkg::ID_MAX), 1,
                     mk_out(rist_pkg::ST_OK, 511, 7, 0)});
    rows.push_back('{mk_in(rist_pkg::ACT_LOAD, 0, 0, 32'd99), 1,
                     mk_out(rist_pkg::ST_OK, 0, 0, 0)});
    rows.push_back('{mk_in(rist_pkg::ACT_LOAD, 1, 3, 32'd7), 1,
                     mk_out(rist_pkg::ST_OK, 1, 3, 0)});
    rows.push_back('{mk_in(rist_pkg::ACT_DONE, 0, 0, 0), 1,
                     mk_out(rist_pkg::ST_OK, 0, 0, 0)});
    rows.push_back('{mk_in(rist_pkg::ACT_DONE, 0, 0, 0), 1,
                     mk_out(rist_pkg::ST_OK, 0, 0, 0)});
    rows.push_back('{mk_in(3'd7, 0, 0, 0), 1, mk_out(rist_pkg::ST_ERR, 0, 0, 0)});
    rows.push_back('{mk_in(rist_pkg::ACT_NEWID, 0, 0, 0), 1,
                     mk_out(rist_pkg::ST_OK, 0, 0, rist_pkg::ID_MAX)});
    rows.push_back('{mk_in(rist_pkg::ACT_PENDING, 0, 0, 0), 1,
                     mk_out(rist_pkg::ST_OK, 1, 3, 7)});
    rows.push_back('{mk_in(rist_pkg::ACT_DELETE, 0, 0, 0), 1,
                     mk_out(rist_pkg::ST_NOTFND, 0, 0, 0)});
    rows.push_back('{mk_in(rist_pkg::ACT_DELETE, 0, 0, 32'd99), 1,
                     mk_out(rist_pkg::ST_NOTFND, 0, 0, 0)});
    rows.push_back('{mk_in(rist_pkg::ACT_DELETE, 0, 0, rist_pkg::ID_MAX), 1,
                     mk_out(rist_pkg::ST_OK, 511, 7, 0)});
    rows.push_back('{mk_in(rist_pkg::ACT_STORE, 0, 0, 32'd11), 1,
                     mk_out(rist_pkg::ST_OK, 1, 0, 0)});
    rows.push_back('{mk_in(rist_pkg::ACT_STORE, 0, 0, 32'd12), 0, '0});
    rows.push_back('{mk_in(rist_pkg::ACT_DELETE, 0, 0, 32'd7), 1,
                     mk_out(rist_pkg::ST_OK, 1, 3, 0)});
    rows.push_back('{mk_in(rist_pkg::ACT_NEWID, 0, 0, 0), 0, '0});
    rows.push_back('{mk_in(rist_pkg::ACT_LOAD, 9'h0AA, 3'h5, 32'h5555_AAAA), 0, '0});
    rows.push_back('{mk_in(rist_pkg::ACT_LOAD, 9'h155, 3'h2, 32'hAAAA_5555), 0, '0});
    rows.push_back('{mk_in(rist_pkg::ACT_PENDING, 0, 0, 0), 0, '0});
    foreach (rows[k]) begin
      send_item(rows[k].item, rows[k].check_exp, rows[k].exp);
      sender_gap();
    end
    drain();

    // Random phases over several register settings
    for (ph = 0; ph < 4; ph++) begin
      write_reg(rist_pkg::CFG_THRESH, ph == 3 ? $urandom_range(25) : thr_set[ph]);
      write_reg(rist_pkg::CFG_FPAGE, {23'd0, fpg_set[ph]});
      write_reg(rist_pkg::CFG_FID, fid_set[ph]);
      cfg_valid <= 1'b0;
      for (i = 0; i < RAND_ITEMS / 4; i++) begin
        case ($urandom_range(9))
          0, 1: it = mk_in(rist_pkg::ACT_LOAD, rand_page(), 3'($urandom_range(7)), rand_id());
          2, 3: it = mk_in(rist_pkg::ACT_STORE, 9'($urandom()), 3'($urandom()), rand_id());
          4, 5: it = mk_in(rist_pkg::ACT_DELETE, 9'($urandom()), 3'($urandom()), rand_id());
          6: it = mk_in(rist_pkg::ACT_PENDING, 9'($urandom()), 3'($urandom()), $urandom());
          7: it = mk_in(rist_pkg::ACT_NEWID, 9'($urandom()), 3'($urandom()), $urandom());
          8: it = mk_in(rist_pkg::ACT_DONE, 9'($urandom()), 3'($urandom()), $urandom());
          default: it = mk_in(3'($urandom_range(7, 6)), 9'($urandom()), 3'($urandom()),
                              $urandom());
        endcase
        send_item(it, 0, '0);
        if (i == 10) begin
          // hold off until every answer is back
          start <= 1'b0;
          while (answer_q.size() != 0) @(posedge clk);
        end else begin
          sender_gap();
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
